// ----- rtl/apt_pkg.sv -----
// Shared widths, register indexes and transaction types for the affine point transform.
package apt_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // signed 32x33 product and the sums built from it
   localparam int PROD_W = 2 * COORD_WIDTH + 1;
   localparam int SUM_W  = 2 * COORD_WIDTH + 3;
   localparam int DET_W  = 2 * COORD_WIDTH + 2;
   // divider operands: numerator is the scaled magnitude plus rounding term
   localparam int NUM_W  = 2 * COORD_WIDTH + FRAC_BITS + 4;
   localparam int DEN_W  = 2 * COORD_WIDTH + 3;
   localparam int CMP_W  = (NUM_W > DEN_W + COORD_WIDTH) ? NUM_W : DEN_W + COORD_WIDTH;

   localparam int CSR_IDX_W = 3;

   // input register, operand select, multiply, sum, scale, divider check,
   // one divider stage per quotient bit, result register
   localparam int LATENCY = 5 + 1 + COORD_WIDTH + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_XX  = 3'd0,
      CSR_COEF_XY  = 3'd1,
      CSR_COEF_YX  = 3'd2,
      CSR_COEF_YY  = 3'd3,
      CSR_OFFSET_X = 3'd4,
      CSR_OFFSET_Y = 3'd5
   } apt_csr_idx_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] xx;
      logic signed [COORD_WIDTH-1:0] xy;
      logic signed [COORD_WIDTH-1:0] yx;
      logic signed [COORD_WIDTH-1:0] yy;
      logic signed [COORD_WIDTH-1:0] tx;
      logic signed [COORD_WIDTH-1:0] ty;
   } apt_coef_type;

   // side information that travels with one coordinate through the divider
   typedef struct packed {
      logic                   neg;
      logic                   bypass;
      logic [COORD_WIDTH-1:0] echo;
   } apt_ctrl_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] value;
      logic                   ovf;
      logic                   singular;
   } apt_res_type;

endpackage

// ----- rtl/apt_front.sv -----
// Front pipeline: operand select, products, sums and divider operand scaling.
module apt_front import apt_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic                          in_mode,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  apt_coef_type                  coef,
   output logic                          out_vld,
   output apt_ctrl_type                  ctrl_x,
   output apt_ctrl_type                  ctrl_y,
   output logic [NUM_W-1:0]              num_x,
   output logic [NUM_W-1:0]              num_y,
   output logic [DEN_W-1:0]              den
);

   // stage A: input capture
   logic                          a_vld_ff;
   logic                          a_mode_ff;
   logic signed [COORD_WIDTH-1:0] a_x_ff, a_y_ff;

   // stage B: multiplier operands
   logic                          b_vld_ff;
   logic                          b_mode_ff;
   logic [COORD_WIDTH-1:0]        b_x_ff, b_y_ff;
   logic signed [COORD_WIDTH:0]   b_u_ff, b_v_ff, b_s_ff, b_t_ff;
   logic signed [COORD_WIDTH:0]   ext_x, ext_y, ext_tx, ext_ty, dx, dy;

   // stage C: products
   logic                          c_vld_ff;
   logic                          c_mode_ff;
   logic [COORD_WIDTH-1:0]        c_x_ff, c_y_ff;
   logic signed [PROD_W-1:0]      c_pa_ff, c_pb_ff, c_pc_ff, c_pd_ff, c_pad_ff, c_pbc_ff;

   // stage D: sums
   logic                          d_vld_ff;
   logic                          d_mode_ff;
   logic [COORD_WIDTH-1:0]        d_x_ff, d_y_ff;
   logic signed [SUM_W-1:0]       d_sx_ff, d_sy_ff;
   logic signed [DET_W-1:0]       d_det_ff;

   // stage E: divider operands
   logic                          e_vld_ff;
   apt_ctrl_type                  e_ctrl_x_ff, e_ctrl_y_ff;
   logic [NUM_W-1:0]              e_num_x_ff, e_num_y_ff;
   logic [DEN_W-1:0]              e_den_ff;

   logic [SUM_W-1:0]              mag_x, mag_y;
   logic [DET_W-1:0]              mag_det;
   logic                          det_zero;
   logic [NUM_W-1:0]              num_x_in, num_y_in;
   logic [DEN_W-1:0]              den_in;
   logic                          neg_x_in, neg_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
      end
   end

   assign ext_x  = {a_x_ff[COORD_WIDTH-1], a_x_ff};
   assign ext_y  = {a_y_ff[COORD_WIDTH-1], a_y_ff};
   assign ext_tx = {coef.tx[COORD_WIDTH-1], coef.tx};
   assign ext_ty = {coef.ty[COORD_WIDTH-1], coef.ty};
   assign dx     = ext_x - ext_tx;
   assign dy     = ext_y - ext_ty;

   assign mag_x    = d_sx_ff[SUM_W-1] ? SUM_W'(-d_sx_ff) : SUM_W'(d_sx_ff);
   assign mag_y    = d_sy_ff[SUM_W-1] ? SUM_W'(-d_sy_ff) : SUM_W'(d_sy_ff);
   assign mag_det  = d_det_ff[DET_W-1] ? DET_W'(-d_det_ff) : DET_W'(d_det_ff);
   assign det_zero = (d_det_ff == '0);

   always_comb begin
      if (d_mode_ff) begin
         // round to nearest of |n| / |det|: (2^(F+1)|n| + |det|) / (2|det|)
         num_x_in = (NUM_W'(mag_x) << (FRAC_BITS + 1)) + NUM_W'(mag_det);
         num_y_in = (NUM_W'(mag_y) << (FRAC_BITS + 1)) + NUM_W'(mag_det);
         den_in   = DEN_W'(mag_det) << 1;
         neg_x_in = d_sx_ff[SUM_W-1] ^ d_det_ff[DET_W-1];
         neg_y_in = d_sy_ff[SUM_W-1] ^ d_det_ff[DET_W-1];
      end else begin
         // round to nearest of |s| / 2^F, posed as a division by 2^(F+1)
         num_x_in = (NUM_W'(mag_x) << 1) + (NUM_W'(1) << FRAC_BITS);
         num_y_in = (NUM_W'(mag_y) << 1) + (NUM_W'(1) << FRAC_BITS);
         den_in   = DEN_W'(1) << (FRAC_BITS + 1);
         neg_x_in = d_sx_ff[SUM_W-1];
         neg_y_in = d_sy_ff[SUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      a_mode_ff <= in_mode;
      a_x_ff    <= in_x;
      a_y_ff    <= in_y;

      b_mode_ff <= a_mode_ff;
      b_x_ff    <= a_x_ff;
      b_y_ff    <= a_y_ff;
      b_u_ff    <= a_mode_ff ? dy : ext_x;
      b_v_ff    <= a_mode_ff ? dy : ext_y;
      b_s_ff    <= a_mode_ff ? dx : ext_x;
      b_t_ff    <= a_mode_ff ? dx : ext_y;

      c_mode_ff <= b_mode_ff;
      c_x_ff    <= b_x_ff;
      c_y_ff    <= b_y_ff;
      c_pa_ff   <= coef.xx * b_u_ff;
      c_pb_ff   <= coef.xy * b_v_ff;
      c_pc_ff   <= coef.yx * b_s_ff;
      c_pd_ff   <= coef.yy * b_t_ff;
      c_pad_ff  <= coef.xx * coef.yy;
      c_pbc_ff  <= coef.xy * coef.yx;

      d_mode_ff <= c_mode_ff;
      d_x_ff    <= c_x_ff;
      d_y_ff    <= c_y_ff;
      if (c_mode_ff) begin
         d_sx_ff <= c_pd_ff - c_pb_ff;
         d_sy_ff <= c_pa_ff - c_pc_ff;
      end else begin
         d_sx_ff <= c_pa_ff + c_pb_ff + (coef.tx <<< FRAC_BITS);
         d_sy_ff <= c_pc_ff + c_pd_ff + (coef.ty <<< FRAC_BITS);
      end
      d_det_ff  <= c_pad_ff - c_pbc_ff;

      e_ctrl_x_ff.neg    <= neg_x_in;
      e_ctrl_x_ff.bypass <= d_mode_ff & det_zero;
      e_ctrl_x_ff.echo   <= d_x_ff;
      e_ctrl_y_ff.neg    <= neg_y_in;
      e_ctrl_y_ff.bypass <= d_mode_ff & det_zero;
      e_ctrl_y_ff.echo   <= d_y_ff;
      e_num_x_ff         <= num_x_in;
      e_num_y_ff         <= num_y_in;
      e_den_ff           <= den_in;
   end

   assign out_vld = e_vld_ff;
   assign ctrl_x  = e_ctrl_x_ff;
   assign ctrl_y  = e_ctrl_y_ff;
   assign num_x   = e_num_x_ff;
   assign num_y   = e_num_y_ff;
   assign den     = e_den_ff;

endmodule

// ----- rtl/apt_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit a stage, with saturation.
module apt_div_pipe import apt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  apt_ctrl_type     in_ctrl,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_vld,
   output apt_res_type      out_res
);

   localparam int QB = COORD_WIDTH;

   logic                   vld_ff  [0:QB];
   apt_ctrl_type           ctrl_ff [0:QB];
   logic                   big_ff  [0:QB];
   logic [QB-1:0]          quo_ff  [0:QB];
   logic [NUM_W-1:0]       rem_ff  [0:QB-1];
   logic [DEN_W-1:0]       den_ff  [0:QB-1];

   logic                   res_vld_ff;
   apt_res_type            res_ff;

   logic [QB-1:0]          lim;
   logic                   sat;
   apt_res_type            res_in;

   // entry: flag quotients that cannot fit in QB bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff[0] <= in_ctrl;
      rem_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      quo_ff[0]  <= '0;
      big_ff[0]  <= CMP_W'(in_num) >= (CMP_W'(in_den) << QB);
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [CMP_W-1:0] sub_val;
      logic             ge;

      assign sub_val = CMP_W'(den_ff[k]) << (QB - 1 - k);
      assign ge      = CMP_W'(rem_ff[k]) >= sub_val;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         ctrl_ff[k+1] <= ctrl_ff[k];
         big_ff[k+1]  <= big_ff[k];
         quo_ff[k+1]  <= {quo_ff[k][QB-2:0], ge};
      end

      if (k < QB - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge ? NUM_W'(CMP_W'(rem_ff[k]) - sub_val) : rem_ff[k];
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   // a negative result may reach one step further than a positive one
   assign lim = ctrl_ff[QB].neg ? (QB'(1) << (QB - 1)) : ((QB'(1) << (QB - 1)) - QB'(1));
   assign sat = big_ff[QB] | (quo_ff[QB] > lim);

   always_comb begin
      res_in.singular = ctrl_ff[QB].bypass;
      if (ctrl_ff[QB].bypass) begin
         res_in.value = ctrl_ff[QB].echo;
         res_in.ovf   = 1'b0;
      end else if (sat) begin
         res_in.value = lim;
         res_in.ovf   = 1'b1;
         if (!ctrl_ff[QB].neg) begin
            res_in.value = lim;
         end
      end else begin
         res_in.value = ctrl_ff[QB].neg ? QB'(-quo_ff[QB]) : quo_ff[QB];
         res_in.ovf   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else begin
         res_vld_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_vld = res_vld_ff;
   assign out_res = res_ff;

endmodule

// ----- rtl/affine_point_transform_unit.sv -----
// Top level of the affine point transform: register file, front pipeline and dividers.
// Throughput: one transaction per cycle; busy stays low, as every stage advances each cycle.
// The divider produces one quotient bit per stage for each coordinate.
// Reset (synchronous) empties the pipeline and loads the identity matrix with zero offset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module affine_point_transform_unit import apt_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic                          rsp_singular,
   output logic                          rsp_overflow,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);

   apt_coef_type     coef_ff;
   logic             front_vld;
   apt_ctrl_type     ctrl_x, ctrl_y;
   logic [NUM_W-1:0] num_x, num_y;
   logic [DEN_W-1:0] den;
   logic             vld_x, vld_y;
   apt_res_type      res_x, res_y;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.xx <= COORD_WIDTH'(1) << FRAC_BITS;
         coef_ff.xy <= '0;
         coef_ff.yx <= '0;
         coef_ff.yy <= COORD_WIDTH'(1) << FRAC_BITS;
         coef_ff.tx <= '0;
         coef_ff.ty <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COEF_XX:  coef_ff.xx <= csr_wdata;
            CSR_COEF_XY:  coef_ff.xy <= csr_wdata;
            CSR_COEF_YX:  coef_ff.yx <= csr_wdata;
            CSR_COEF_YY:  coef_ff.yy <= csr_wdata;
            CSR_OFFSET_X: coef_ff.tx <= csr_wdata;
            CSR_OFFSET_Y: coef_ff.ty <= csr_wdata;
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   apt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start && !busy),
      .in_mode (req_mode),
      .in_x    (req_point_x),
      .in_y    (req_point_y),
      .coef    (coef_ff),
      .out_vld (front_vld),
      .ctrl_x  (ctrl_x),
      .ctrl_y  (ctrl_y),
      .num_x   (num_x),
      .num_y   (num_y),
      .den     (den)
   );

   apt_div_pipe u_div_x (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (front_vld),
      .in_ctrl (ctrl_x),
      .in_num  (num_x),
      .in_den  (den),
      .out_vld (vld_x),
      .out_res (res_x)
   );

   apt_div_pipe u_div_y (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (front_vld),
      .in_ctrl (ctrl_y),
      .in_num  (num_y),
      .in_den  (den),
      .out_vld (vld_y),
      .out_res (res_y)
   );

   assign rsp_valid    = vld_x;
   assign rsp_out_x    = res_x.value;
   assign rsp_out_y    = res_y.value;
   assign rsp_singular = res_x.singular;
   assign rsp_overflow = res_x.ovf | res_y.ovf;

   localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      vld_x == vld_y)
      else $error("coordinate lanes out of step");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transaction result missing at expected latency");

   a_singular_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_singular && rsp_overflow))
      else $error("singular result flagged as overflow");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_out_x == SAT_MAX || rsp_out_x == SAT_MIN ||
                                       rsp_out_y == SAT_MAX || rsp_out_y == SAT_MIN))
      else $error("overflow without a saturated coordinate");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the affine point transform: directed and random transactions.
`timescale 1ns / 100ps

module testbench;
   import apt_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic                          sing;
      logic                          ovf;
   } point_result_type;

   localparam int CYCLE_LIMIT = 400000;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_mode;
   logic signed [COORD_WIDTH-1:0] req_point_x;
   logic signed [COORD_WIDTH-1:0] req_point_y;
   logic                          rsp_valid;
   logic signed [COORD_WIDTH-1:0] rsp_out_x;
   logic signed [COORD_WIDTH-1:0] rsp_out_y;
   logic                          rsp_singular;
   logic                          rsp_overflow;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [COORD_WIDTH-1:0]        csr_wdata;

   logic signed [COORD_WIDTH-1:0] coef [6];
   point_result_type              results_pending [$];
   int                            error_count;
   int                            points_sent;
   int                            points_checked;
   int                            config_writes;
   int                            singular_seen;
   int                            overflow_seen;
   int                            idle_pct;
   int                            cycle_count;

   affine_point_transform_unit dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .rsp_valid    (rsp_valid),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_singular (rsp_singular),
      .rsp_overflow (rsp_overflow),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic saturate(input wide_type mag, input logic neg,
                                     output logic signed [COORD_WIDTH-1:0] val);
      wide_type lim;
      logic     ovf;
      lim = neg ? (wide_type'(1) <<< (COORD_WIDTH - 1))
                : (wide_type'(1) <<< (COORD_WIDTH - 1)) - wide_type'(1);
      ovf = (mag > lim);
      if (ovf) mag = lim;
      if (neg) mag = -mag;
      val = mag[COORD_WIDTH-1:0];
      return ovf;
   endfunction

   function automatic logic round_scaled(input wide_type v,
                                         output logic signed [COORD_WIDTH-1:0] val);
      logic     neg;
      wide_type mag;
      neg = v < 0;
      mag = (neg ? -v : v) + (wide_type'(1) <<< (FRAC_BITS - 1));
      mag = mag >>> FRAC_BITS;
      return saturate(mag, neg, val);
   endfunction

   function automatic logic round_quotient(input wide_type num, input wide_type den,
                                           output logic signed [COORD_WIDTH-1:0] val);
      logic     neg;
      wide_type an;
      wide_type ad;
      wide_type q;
      neg = (num < 0) ^ (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = ((an <<< (FRAC_BITS + 1)) + ad) / (ad <<< 1);
      return saturate(q, neg, val);
   endfunction

   function automatic point_result_type transform_point(input logic m,
                                                        input logic signed [COORD_WIDTH-1:0] px,
                                                        input logic signed [COORD_WIDTH-1:0] py);
      wide_type a, b, c, d, tx, ty, x, y, det, dx, dy;
      point_result_type r;
      logic o1, o2;
      a  = coef[CSR_COEF_XX];
      b  = coef[CSR_COEF_XY];
      c  = coef[CSR_COEF_YX];
      d  = coef[CSR_COEF_YY];
      tx = coef[CSR_OFFSET_X];
      ty = coef[CSR_OFFSET_Y];
      x  = px;
      y  = py;
      r.sing = 1'b0;
      r.ovf  = 1'b0;
      r.x    = px;
      r.y    = py;
      o1 = 1'b0;
      o2 = 1'b0;
      if (!m) begin
         o1 = round_scaled(a * x + b * y + (tx <<< FRAC_BITS), r.x);
         o2 = round_scaled(c * x + d * y + (ty <<< FRAC_BITS), r.y);
      end else begin
         det = a * d - b * c;
         if (det == 0) begin
            r.sing = 1'b1;
         end else begin
            dx = x - tx;
            dy = y - ty;
            o1 = round_quotient(d * dx - b * dy, det, r.x);
            o2 = round_quotient(a * dy - c * dx, det, r.y);
         end
      end
      r.ovf = o1 | o2;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report(input string what, input logic [COORD_WIDTH-1:0] got,
                         input logic [COORD_WIDTH-1:0] want);
      $display("mismatch %0s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      point_result_type e;
      if (!reset && rsp_valid) begin
         if (results_pending.size() == 0) begin
            report("unexpected transaction", rsp_out_x, '0);
         end else begin
            e = results_pending.pop_front();
            points_checked++;
            if (rsp_out_x !== e.x) report("out_x", rsp_out_x, e.x);
            if (rsp_out_y !== e.y) report("out_y", rsp_out_y, e.y);
            if (rsp_singular !== e.sing) report("singular", rsp_singular, e.sing);
            if (rsp_overflow !== e.ovf) report("overflow", rsp_overflow, e.ovf);
            if (e.sing) singular_seen++;
            if (e.ovf) overflow_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   // entered and left at a falling edge
   task automatic send_point(input logic m, input logic signed [COORD_WIDTH-1:0] px,
                             input logic signed [COORD_WIDTH-1:0] py);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start       = 1'b1;
      req_mode    = m;
      req_point_x = px;
      req_point_y = py;
      do @(posedge clock); while (busy);
      results_pending.push_back(transform_point(m, px, py));
      points_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain;
      while (results_pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_WIDTH-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      if (idx <= CSR_OFFSET_Y) coef[idx] = val;
      config_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_matrix(input logic [COORD_WIDTH-1:0] a, input logic [COORD_WIDTH-1:0] b,
                              input logic [COORD_WIDTH-1:0] c, input logic [COORD_WIDTH-1:0] d,
                              input logic [COORD_WIDTH-1:0] tx, input logic [COORD_WIDTH-1:0] ty);
      drain();
      write_reg(CSR_COEF_XX, a);
      write_reg(CSR_COEF_XY, b);
      write_reg(CSR_COEF_YX, c);
      write_reg(CSR_COEF_YY, d);
      write_reg(CSR_OFFSET_X, tx);
      write_reg(CSR_OFFSET_Y, ty);
   endtask

   function automatic logic [COORD_WIDTH-1:0] pick_value(input int small_range);
      logic [COORD_WIDTH-1:0] v;
      case ($urandom_range(3))
         0: v = $urandom_range(2 * small_range) - small_range;
         1: case ($urandom_range(4))
               0: v = 32'h7fff_ffff;
               1: v = 32'h8000_0000;
               2: v = 32'h0001_0000;
               3: v = 32'hffff_ffff;
               default: v = '0;
            endcase
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_identity_after_reset;
      send_point(1'b0, 32'sh0003_8000, -32'sh0001_4000);
      send_point(1'b1, 32'sh7fff_ffff, 32'sh8000_0000);
      send_point(1'b0, 32'sh8000_0000, 32'sh7fff_ffff);
   endtask

   task automatic test_extremes;
      load_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h8000_0000);
      send_point(1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_point(1'b0, 32'sh8000_0000, 32'sh8000_0000);
      send_point(1'b1, 32'sh7fff_ffff, 32'sh8000_0000);
      send_point(1'b1, 32'sh8000_0000, 32'sh7fff_ffff);
      send_point(1'b0, 32'sh0000_0000, 32'sh0000_0000);
      send_point(1'b1, 32'sh0000_0000, 32'sh0000_0000);
      // tiny determinant: inverse blows up and saturates
      load_matrix(32'h0000_0001, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0);
      send_point(1'b1, 32'sh0001_0000, -32'sh0001_0000);
      send_point(1'b1, 32'sh0000_0001, 32'sh0000_0000);
      send_point(1'b0, 32'sh0000_8000, -32'sh0000_8000);
      // rounding ties on halves
      load_matrix(32'h0000_8000, 32'h0, 32'h0, 32'hffff_8000, 32'h0, 32'h0);
      send_point(1'b0, 32'sh0000_0001, 32'sh0000_0001);
      send_point(1'b0, 32'sh0000_0003, -32'sh0000_0003);
      send_point(1'b1, 32'sh0000_0001, -32'sh0000_0001);
   endtask

   task automatic test_singular;
      load_matrix(32'h0002_0000, 32'h0001_0000, 32'h0004_0000, 32'h0002_0000,
                  32'h0000_1234, 32'hffff_0000);
      send_point(1'b1, 32'sh1234_5678, -32'sh0765_4321);
      send_point(1'b1, 32'sh7fff_ffff, 32'sh8000_0000);
      send_point(1'b0, 32'sh1234_5678, -32'sh0765_4321);
      load_matrix(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_point(1'b1, 32'sh0000_0001, 32'sh0000_0002);
      send_point(1'b0, 32'sh7fff_ffff, 32'sh8000_0000);
   endtask

   task automatic test_unknown_index;
      drain();
      write_reg(3'd6, 32'hdead_beef);
      write_reg(3'd7, 32'h1234_5678);
      send_point(1'b1, 32'sh0001_0000, 32'sh0002_0000);
      send_point(1'b0, 32'sh0001_0000, 32'sh0002_0000);
   endtask

   task automatic test_random_points;
      int pct [3];
      logic [COORD_WIDTH-1:0] a, b, c, d;
      pct = '{0, 62, 14};
      for (int blk = 0; blk < 6; blk++) begin
         idle_pct = 0;
         a = pick_value(32'h0004_0000);
         b = pick_value(32'h0004_0000);
         c = pick_value(32'h0004_0000);
         d = pick_value(32'h0004_0000);
         // force a singular matrix in block 2
         if (blk == 2) begin
            c = a;
            d = b;
         end
         load_matrix(a, b, c, d, pick_value(32'h0100_0000), pick_value(32'h0100_0000));
         idle_pct = pct[blk % 3];
         for (int i = 0; i < 108; i++) begin
            send_point($urandom_range(1), pick_value(32'h0100_0000),
                       pick_value(32'h0100_0000));
         end
      end
      idle_pct = 0;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = 1'b0;
      req_point_x    = '0;
      req_point_y    = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      error_count    = 0;
      points_sent    = 0;
      points_checked = 0;
      config_writes  = 0;
      singular_seen  = 0;
      overflow_seen  = 0;
      idle_pct       = 0;
      cycle_count    = 0;
      coef = '{32'sh0001_0000, 0, 0, 32'sh0001_0000, 0, 0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_identity_after_reset();
      test_extremes();
      test_singular();
      test_unknown_index();
      test_random_points();

      drain();
      $display("covered %0d transactions, %0d checked, %0d register writes",
               points_sent, points_checked, config_writes);
      $display("singular results %0d, saturated results %0d, mismatches %0d",
               singular_seen, overflow_seen, error_count);
      if (error_count == 0 && results_pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
